// File: rtl/lras_pkg.sv
package lras_pkg;

  // Ramp and slot geometry
  localparam int RAMP_LEN = 8;
  localparam int RAMP_W   = $clog2(RAMP_LEN);
  localparam int NSLOTS   = 5;
  localparam int SLOT_W   = $clog2(NSLOTS);

  // Shared multiplier operand and accumulator widths
  localparam int MAC_W = 21;
  localparam int ACC_W = 2 * MAC_W;

  // floor(x / 255) = (x * DIV255_MAGIC) >> DIV255_SHIFT for x below 2^20
  localparam logic [MAC_W-1:0] DIV255_MAGIC = 21'd1052689;
  localparam int               DIV255_SHIFT = 28;

  // Register reset values
  localparam logic [11:0] LCD_MAX_RST  = 12'd3200;
  localparam logic [7:0]  BTN_MAX_RST  = 8'd255;
  localparam logic [9:0]  STEP_MS_RST  = 10'd50;

  // Register indexes
  localparam logic [1:0] REG_LCD_MAX = 2'd0;
  localparam logic [1:0] REG_BTN_MAX = 2'd1;
  localparam logic [1:0] REG_STEP_MS = 2'd2;

  // Light types
  localparam logic [2:0] LT_BACKLIGHT = 3'd0;
  localparam logic [2:0] LT_BUTTONS   = 3'd2;
  localparam logic [2:0] LT_BATTERY   = 3'd3;
  localparam logic [2:0] LT_NOTIFY    = 3'd4;
  localparam logic [2:0] LT_ATTENTION = 3'd5;

  // Slots in priority order
  localparam logic [SLOT_W-1:0] SLOT_ATTN  = 3'd0;
  localparam logic [SLOT_W-1:0] SLOT_NOTE  = 3'd1;
  localparam logic [SLOT_W-1:0] SLOT_BATT  = 3'd2;
  localparam logic [SLOT_W-1:0] SLOT_LCD   = 3'd3;
  localparam logic [SLOT_W-1:0] SLOT_BTN   = 3'd4;

  // Output groups
  localparam logic [1:0] GRP_RGB = 2'd0;
  localparam logic [1:0] GRP_LCD = 2'd1;
  localparam logic [1:0] GRP_BTN = 2'd2;

  // Flash kinds
  localparam logic [1:0] FLASH_TIMED = 2'd1;

  // Write targets
  localparam logic [2:0] TGT_LCD     = 3'd0;
  localparam logic [2:0] TGT_BUTTON  = 3'd1;
  localparam logic [2:0] TGT_BUTTON1 = 3'd2;
  localparam logic [2:0] TGT_RED     = 3'd3;
  localparam logic [2:0] TGT_RGB     = 3'd6;
  localparam logic [2:0] TGT_NONE    = 3'd7;

  // Write attributes
  localparam logic [2:0] ATTR_BRIGHT   = 3'd0;
  localparam logic [2:0] ATTR_BLINK    = 3'd1;
  localparam logic [2:0] ATTR_START    = 3'd2;
  localparam logic [2:0] ATTR_DUTY     = 3'd3;
  localparam logic [2:0] ATTR_PAUSE_LO = 3'd4;
  localparam logic [2:0] ATTR_PAUSE_HI = 3'd5;
  localparam logic [2:0] ATTR_STEP     = 3'd6;

  // Status codes
  localparam logic ST_OK    = 1'b0;
  localparam logic ST_NOSUP = 1'b1;

  // Luma weights
  localparam logic [7:0] LUMA_R = 8'd77;
  localparam logic [7:0] LUMA_G = 8'd150;
  localparam logic [7:0] LUMA_B = 8'd29;

  typedef struct packed {
    logic [2:0]  light_type;
    logic [31:0] argb_color;
    logic [1:0]  flash_kind;
    logic [23:0] on_time_ms;
    logic [23:0] off_time_ms;
  } lras_in_t;

  typedef struct packed {
    logic        status;
    logic [2:0]  target;
    logic [2:0]  attribute;
    logic [2:0]  ramp_step;
    logic [23:0] value;
    logic        last;
  } lras_out_t;

  typedef struct packed {
    logic [31:0] color;
    logic [1:0]  flash;
    logic [23:0] on_ms;
    logic [23:0] off_ms;
  } lras_slot_t;

  typedef struct packed {
    logic              ok;
    logic [SLOT_W-1:0] slot;
  } lras_sel_t;

  typedef struct packed {
    logic             en;
    logic             acc;
    logic [MAC_W-1:0] a;
    logic [MAC_W-1:0] b;
  } lras_mac_req_t;

  // Map a light type onto its slot
  function automatic lras_sel_t slot_of(input logic [2:0] lt);
    lras_sel_t s;
    s.ok = 1'b1;
    case (lt)
      LT_ATTENTION: s.slot = SLOT_ATTN;
      LT_NOTIFY:    s.slot = SLOT_NOTE;
      LT_BATTERY:   s.slot = SLOT_BATT;
      LT_BACKLIGHT: s.slot = SLOT_LCD;
      LT_BUTTONS:   s.slot = SLOT_BTN;
      default: begin
        s.ok   = 1'b0;
        s.slot = SLOT_ATTN;
      end
    endcase
    return s;
  endfunction

  function automatic logic [1:0] group_of(input logic [SLOT_W-1:0] slot);
    logic [1:0] g;
    if (slot <= SLOT_BATT) g = GRP_RGB;
    else if (slot == SLOT_LCD) g = GRP_LCD;
    else g = GRP_BTN;
    return g;
  endfunction

  // Exact floor(x / 255) for x up to 255 * 255
  function automatic logic [7:0] div255_16(input logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return s[15:8];
  endfunction

  // Duty ramp in percent
  function automatic logic [6:0] duty_pct(input logic [RAMP_W-1:0] k);
    logic [6:0] d;
    case (k)
      3'd0:    d = 7'd0;
      3'd1:    d = 7'd12;
      3'd2:    d = 7'd25;
      3'd3:    d = 7'd37;
      3'd4:    d = 7'd50;
      3'd5:    d = 7'd72;
      3'd6:    d = 7'd85;
      3'd7:    d = 7'd100;
      default: d = 7'd0;
    endcase
    return d;
  endfunction

endpackage

// File: rtl/lras_mac.sv
module lras_mac (
  input  logic                              clk,
  input  lras_pkg::lras_mac_req_t           req,
  output logic [lras_pkg::ACC_W-1:0]        res
);

  logic [lras_pkg::ACC_W-1:0] res_r;
  logic [lras_pkg::ACC_W-1:0] prod;

  // Multiply, optionally adding onto the held result
  assign prod = req.a * req.b;

  always_ff @(posedge clk) begin
    if (req.en) begin
      res_r <= (req.acc ? res_r : '0) + prod;
    end
  end

  assign res = res_r;

endmodule

// File: rtl/lras_slots.sv
module lras_slots (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              wr_en,
  input  logic [lras_pkg::SLOT_W-1:0]       wr_slot,
  input  lras_pkg::lras_slot_t              wr_data,
  input  logic [lras_pkg::SLOT_W-1:0]       rd_slot,
  output lras_pkg::lras_slot_t              rd_data,
  output logic [lras_pkg::NSLOTS-1:0]       lit
);

  lras_pkg::lras_slot_t              slot_r [lras_pkg::NSLOTS];
  logic [lras_pkg::NSLOTS-1:0]       lit_r;

  // Hold the cached request of each slot
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_r[wr_slot] <= wr_data;
    end
  end

  // Track which slots carry a visible colour
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lit_r <= '0;
    end else if (wr_en) begin
      lit_r[wr_slot] <= (wr_data.color[23:0] != 24'd0);
    end
  end

  assign rd_data = slot_r[rd_slot];
  assign lit     = lit_r;

endmodule

// File: rtl/led_request_arbiter_and_ramp_setup.sv
// Light request arbiter and LED register write sequencer.
//
// in_*  : one light request per handshake (type, ARGB colour, flash kind,
//         on and off times). in_ready is high only while the block is idle.
// out_* : one LED register write per handshake; last marks the final write
//         of a request. A one-entry output register holds the write.
// cfg_* : register writes (index, data), always ready, taken at any time.
//
// Each request runs as a sequence over one shared multiply-accumulate unit:
// alpha scaling, luma, level scaling and the duty ramp all go through it.
// In timed mode of the RGB group, each duty step runs a multiply on the
// shared unit before its write.
// A stall on out_ready holds the sequence at its current write; the next
// request is taken once the final write has been loaded into the output
// register. Synchronous reset clears the slot lit flags (all slots unlit),
// restores the register defaults and empties the output register.
module led_request_arbiter_and_ramp_setup (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  lras_pkg::lras_in_t    in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output lras_pkg::lras_out_t   out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [11:0]           cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE, S_ERR, S_PICK, S_SCL_MUL, S_SCL_TAKE, S_LUMA_MUL, S_LUMA_TAKE,
    S_LVL_MUL, S_LVL_DIV, S_LVL_TAKE, S_EMIT_LVL, S_BLINK_OFF, S_CH, S_SPAN,
    S_START, S_DUTY_MUL, S_DUTY_EMIT, S_PAUSE_LO, S_PAUSE_HI, S_STEP, S_BLINK_ON
  } state_t;

  localparam int SPAN_W = 10 + lras_pkg::RAMP_W + 1;

  state_t                               state_r, state_nxt;
  logic [lras_pkg::SLOT_W-1:0]          slot_r, slot_nxt;
  logic [1:0]                           grp_r, grp_nxt;
  lras_pkg::lras_slot_t                 cur_r, cur_nxt;
  logic [7:0]                           ch_r [3];
  logic [7:0]                           ch_nxt [3];
  logic [1:0]                           chan_r, chan_nxt;
  logic [lras_pkg::RAMP_W-1:0]          step_r, step_nxt;
  logic [7:0]                           luma_r, luma_nxt;
  logic [11:0]                          level_r, level_nxt;
  logic [9:0]                           dstep_r, dstep_nxt;
  logic [23:0]                          hi_r, hi_nxt;
  logic [11:0]                          lcd_max_r, lcd_max_nxt;
  logic [7:0]                           btn_max_r, btn_max_nxt;
  logic [9:0]                           step_ms_r, step_ms_nxt;
  logic                                 out_valid_r, out_valid_nxt;
  lras_pkg::lras_out_t                  out_data_r, out_data_nxt;

  logic                                 in_acc;
  logic                                 out_free;
  logic                                 emit;
  lras_pkg::lras_out_t                  emit_data;
  lras_pkg::lras_sel_t                  sel;
  lras_pkg::lras_slot_t                 wr_data;
  lras_pkg::lras_slot_t                 rd_data;
  logic [lras_pkg::NSLOTS-1:0]          lit;
  logic [lras_pkg::SLOT_W-1:0]          pick;
  lras_pkg::lras_mac_req_t              mac_req;
  logic [lras_pkg::ACC_W-1:0]           mac_res;
  logic [7:0]                           raw_ch;
  logic [7:0]                           ch_sel;
  logic [7:0]                           luma_coef;
  logic [2:0]                           chan_tgt;
  logic [SPAN_W-1:0]                    span;

  // Slot cache and shared arithmetic unit
  lras_slots u_slots (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_acc & sel.ok),
    .wr_slot (sel.slot),
    .wr_data (wr_data),
    .rd_slot (pick),
    .rd_data (rd_data),
    .lit     (lit)
  );

  lras_mac u_mac (
    .clk (clk),
    .req (mac_req),
    .res (mac_res)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid & in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

  assign sel = lras_pkg::slot_of(in_data.light_type);

  assign wr_data.color  = in_data.argb_color;
  assign wr_data.flash  = in_data.flash_kind;
  assign wr_data.on_ms  = in_data.on_time_ms;
  assign wr_data.off_ms = in_data.off_time_ms;

  // Pick the highest priority lit slot of the RGB group, else the request's slot
  always_comb begin
    pick = slot_r;
    if (grp_r == lras_pkg::GRP_RGB) begin
      if (lit[lras_pkg::SLOT_ATTN]) pick = lras_pkg::SLOT_ATTN;
      else if (lit[lras_pkg::SLOT_NOTE]) pick = lras_pkg::SLOT_NOTE;
      else if (lit[lras_pkg::SLOT_BATT]) pick = lras_pkg::SLOT_BATT;
    end
  end

  // Select per-channel operands
  always_comb begin
    case (chan_r)
      2'd0: begin
        raw_ch    = cur_r.color[23:16];
        ch_sel    = ch_r[0];
        luma_coef = lras_pkg::LUMA_R;
      end
      2'd1: begin
        raw_ch    = cur_r.color[15:8];
        ch_sel    = ch_r[1];
        luma_coef = lras_pkg::LUMA_G;
      end
      default: begin
        raw_ch    = cur_r.color[7:0];
        ch_sel    = ch_r[2];
        luma_coef = lras_pkg::LUMA_B;
      end
    endcase
  end

  assign chan_tgt = lras_pkg::TGT_RED + {1'b0, chan_r};
  assign span     = {step_ms_r, {(lras_pkg::RAMP_W + 1){1'b0}}};

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    slot_nxt    = slot_r;
    grp_nxt     = grp_r;
    cur_nxt     = cur_r;
    ch_nxt      = ch_r;
    chan_nxt    = chan_r;
    step_nxt    = step_r;
    luma_nxt    = luma_r;
    level_nxt   = level_r;
    dstep_nxt   = dstep_r;
    hi_nxt      = hi_r;
    mac_req     = '0;
    emit        = 1'b0;
    emit_data   = '0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          slot_nxt  = sel.slot;
          grp_nxt   = lras_pkg::group_of(sel.slot);
          chan_nxt  = 2'd0;
          state_nxt = sel.ok ? S_PICK : S_ERR;
        end
      end
      S_ERR: begin
        if (out_free) begin
          emit             = 1'b1;
          emit_data.status = lras_pkg::ST_NOSUP;
          emit_data.target = lras_pkg::TGT_NONE;
          emit_data.last   = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      S_PICK: begin
        cur_nxt   = rd_data;
        state_nxt = S_SCL_MUL;
      end
      S_SCL_MUL: begin
        mac_req.en = 1'b1;
        mac_req.a  = lras_pkg::MAC_W'(raw_ch);
        mac_req.b  = lras_pkg::MAC_W'(cur_r.color[31:24]);
        state_nxt  = S_SCL_TAKE;
      end
      S_SCL_TAKE: begin
        ch_nxt[chan_r] = lras_pkg::div255_16(mac_res[15:0]);
        if (chan_r == 2'd2) begin
          chan_nxt  = 2'd0;
          state_nxt = (grp_r == lras_pkg::GRP_RGB) ? S_BLINK_OFF : S_LUMA_MUL;
        end else begin
          chan_nxt  = chan_r + 2'd1;
          state_nxt = S_SCL_MUL;
        end
      end
      S_LUMA_MUL: begin
        mac_req.en  = 1'b1;
        mac_req.acc = (chan_r != 2'd0);
        mac_req.a   = lras_pkg::MAC_W'(luma_coef);
        mac_req.b   = lras_pkg::MAC_W'(ch_sel);
        if (chan_r == 2'd2) begin
          chan_nxt  = 2'd0;
          state_nxt = S_LUMA_TAKE;
        end else begin
          chan_nxt = chan_r + 2'd1;
        end
      end
      S_LUMA_TAKE: begin
        luma_nxt  = mac_res[15:8];
        state_nxt = S_LVL_MUL;
      end
      S_LVL_MUL: begin
        mac_req.en = 1'b1;
        mac_req.a  = lras_pkg::MAC_W'(luma_r);
        mac_req.b  = (grp_r == lras_pkg::GRP_LCD) ? lras_pkg::MAC_W'(lcd_max_r)
                                                  : lras_pkg::MAC_W'(btn_max_r);
        state_nxt  = S_LVL_DIV;
      end
      S_LVL_DIV: begin
        // Display level needs the wide reciprocal, buttons fit 16 bits
        if (grp_r == lras_pkg::GRP_LCD) begin
          mac_req.en = 1'b1;
          mac_req.a  = mac_res[lras_pkg::MAC_W-1:0];
          mac_req.b  = lras_pkg::DIV255_MAGIC;
          state_nxt  = S_LVL_TAKE;
        end else begin
          level_nxt = {4'd0, lras_pkg::div255_16(mac_res[15:0])};
          state_nxt = S_EMIT_LVL;
        end
      end
      S_LVL_TAKE: begin
        level_nxt = mac_res[lras_pkg::DIV255_SHIFT +: 12];
        state_nxt = S_EMIT_LVL;
      end
      S_EMIT_LVL: begin
        if (out_free) begin
          emit            = 1'b1;
          emit_data.value = {12'd0, level_r};
          if (grp_r == lras_pkg::GRP_LCD) begin
            emit_data.target = lras_pkg::TGT_LCD;
            emit_data.last   = 1'b1;
            state_nxt        = S_IDLE;
          end else if (chan_r == 2'd0) begin
            emit_data.target = lras_pkg::TGT_BUTTON;
            chan_nxt         = 2'd1;
          end else begin
            emit_data.target = lras_pkg::TGT_BUTTON1;
            emit_data.last   = 1'b1;
            chan_nxt         = 2'd0;
            state_nxt        = S_IDLE;
          end
        end
      end
      S_BLINK_OFF: begin
        if (out_free) begin
          emit                = 1'b1;
          emit_data.target    = lras_pkg::TGT_RGB;
          emit_data.attribute = lras_pkg::ATTR_BLINK;
          state_nxt = (cur_r.flash == lras_pkg::FLASH_TIMED) ? S_SPAN : S_CH;
        end
      end
      S_CH: begin
        if (out_free) begin
          emit             = 1'b1;
          emit_data.target = chan_tgt;
          emit_data.value  = {16'd0, ch_sel};
          emit_data.last   = (chan_r == 2'd2);
          if (chan_r == 2'd2) begin
            chan_nxt  = 2'd0;
            state_nxt = S_IDLE;
          end else begin
            chan_nxt = chan_r + 2'd1;
          end
        end
      end
      S_SPAN: begin
        // Shorten the step when the on time cannot hold a full ramp up and down
        if (cur_r.on_ms < 24'(span)) begin
          dstep_nxt = 10'(cur_r.on_ms >> (lras_pkg::RAMP_W + 1));
          hi_nxt    = 24'd0;
        end else begin
          dstep_nxt = step_ms_r;
          hi_nxt    = cur_r.on_ms - 24'(span);
        end
        state_nxt = S_START;
      end
      S_START: begin
        if (out_free) begin
          emit                = 1'b1;
          emit_data.target    = chan_tgt;
          emit_data.attribute = lras_pkg::ATTR_START;
          emit_data.value     = 24'({chan_r, {lras_pkg::RAMP_W{1'b0}}});
          step_nxt            = '0;
          state_nxt           = S_DUTY_MUL;
        end
      end
      S_DUTY_MUL: begin
        mac_req.en = 1'b1;
        mac_req.a  = lras_pkg::MAC_W'(lras_pkg::duty_pct(step_r));
        mac_req.b  = lras_pkg::MAC_W'(ch_sel);
        state_nxt  = S_DUTY_EMIT;
      end
      S_DUTY_EMIT: begin
        if (out_free) begin
          emit                = 1'b1;
          emit_data.target    = chan_tgt;
          emit_data.attribute = lras_pkg::ATTR_DUTY;
          emit_data.ramp_step = step_r;
          emit_data.value     = {16'd0, lras_pkg::div255_16(mac_res[15:0])};
          if (step_r == lras_pkg::RAMP_W'(lras_pkg::RAMP_LEN - 1)) begin
            step_nxt  = '0;
            state_nxt = S_PAUSE_LO;
          end else begin
            step_nxt  = step_r + 1'b1;
            state_nxt = S_DUTY_MUL;
          end
        end
      end
      S_PAUSE_LO: begin
        if (out_free) begin
          emit                = 1'b1;
          emit_data.target    = chan_tgt;
          emit_data.attribute = lras_pkg::ATTR_PAUSE_LO;
          emit_data.value     = cur_r.off_ms;
          state_nxt           = S_PAUSE_HI;
        end
      end
      S_PAUSE_HI: begin
        if (out_free) begin
          emit                = 1'b1;
          emit_data.target    = chan_tgt;
          emit_data.attribute = lras_pkg::ATTR_PAUSE_HI;
          emit_data.value     = hi_r;
          state_nxt           = S_STEP;
        end
      end
      S_STEP: begin
        if (out_free) begin
          emit                = 1'b1;
          emit_data.target    = chan_tgt;
          emit_data.attribute = lras_pkg::ATTR_STEP;
          emit_data.value     = {14'd0, dstep_r};
          if (chan_r == 2'd2) begin
            chan_nxt  = 2'd0;
            state_nxt = S_BLINK_ON;
          end else begin
            chan_nxt  = chan_r + 2'd1;
            state_nxt = S_START;
          end
        end
      end
      S_BLINK_ON: begin
        if (out_free) begin
          emit                = 1'b1;
          emit_data.target    = lras_pkg::TGT_RGB;
          emit_data.attribute = lras_pkg::ATTR_BLINK;
          emit_data.value     = 24'd1;
          emit_data.last      = 1'b1;
          state_nxt           = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Load the output register on a write, drop it once taken
  always_comb begin
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_data_nxt  = emit_data;
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Decode configuration writes
  always_comb begin
    lcd_max_nxt = lcd_max_r;
    btn_max_nxt = btn_max_r;
    step_ms_nxt = step_ms_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lras_pkg::REG_LCD_MAX: lcd_max_nxt = cfg_data;
        lras_pkg::REG_BTN_MAX: btn_max_nxt = cfg_data[7:0];
        lras_pkg::REG_STEP_MS: step_ms_nxt = cfg_data[9:0];
        default: begin
          lcd_max_nxt = lcd_max_r;
        end
      endcase
    end
  end

  // Hold state, working registers and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      chan_r      <= 2'd0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      lcd_max_r   <= lras_pkg::LCD_MAX_RST;
      btn_max_r   <= lras_pkg::BTN_MAX_RST;
      step_ms_r   <= lras_pkg::STEP_MS_RST;
    end else begin
      state_r     <= state_nxt;
      chan_r      <= chan_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      lcd_max_r   <= lcd_max_nxt;
      btn_max_r   <= btn_max_nxt;
      step_ms_r   <= step_ms_nxt;
    end
    slot_r     <= slot_nxt;
    grp_r      <= grp_nxt;
    cur_r      <= cur_nxt;
    ch_r       <= ch_nxt;
    luma_r     <= luma_nxt;
    level_r    <= level_nxt;
    dstep_r    <= dstep_nxt;
    hi_r       <= hi_nxt;
    out_data_r <= out_data_nxt;
  end

  // Checks
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("request taken while a sequence was starting");

  a_last_ends_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && emit_data.last) |=> (state_r == S_IDLE))
    else $error("sequence did not end after its final write");

  a_nosup_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status == lras_pkg::ST_NOSUP) |->
      (out_data_r.target == lras_pkg::TGT_NONE && out_data_r.last))
    else $error("malformed not-supported result");

  a_step_only_duty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.attribute != lras_pkg::ATTR_DUTY) |->
      (out_data_r.ramp_step == '0))
    else $error("ramp step set on a write that is not a duty write");

  a_chan_range: assert property (@(posedge clk) disable iff (!rst_n)
    chan_r != 2'd3)
    else $error("channel counter out of range");

endmodule
